// ===== src/latency_histogram_percentile_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the latency histogram core
// Implication checks sampled on the rising clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_PERCENTILE_CORE_ASSERT_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_CORE_ASSERT_SVH

// same-cycle implication
`define LHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lhp_pkg.sv =====
// ----------------------------------------------------------------------------
// Latency histogram package
// Widths, request codes and item types shared by the core and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package lhp_pkg;

  localparam int unsigned BUCKETS    = 32;
  localparam int unsigned HIST_DEPTH = 2 * BUCKETS;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned BKT_W      = $clog2(BUCKETS);

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BYTES_W = 48;
  localparam int unsigned LAT_W   = 48;
  localparam int unsigned PCT_W   = 10;
  localparam int unsigned BIDX_W  = 5;
  localparam int unsigned ANS_W   = 32;

  localparam int unsigned NS_PER_US = 1000;
  localparam int unsigned PCT_FULL  = 1000;

  // product of total and percentile, and the scaled running sum of the walk
  localparam int unsigned PROD_W = CNT_W + PCT_W;
  localparam int unsigned ACC_W  = CNT_W + BKT_W + 1 + PCT_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD       = 2'd0,
    REQ_QUERY        = 2'd1,
    REQ_WINDOW_RESET = 2'd2
  } req_kind_e;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic               is_read;
    logic [CNT_W-1:0]   byte_count;
    logic [LAT_W-1:0]   latency_ns;
    logic [PCT_W-1:0]   pct_tenths;
  } req_t;

  typedef struct packed {
    logic [BIDX_W-1:0]  bucket_index;
    logic [ANS_W-1:0]   percentile_us;
    logic [CNT_W-1:0]   direction_total;
    logic [CNT_W-1:0]   direction_window;
    logic [BYTES_W-1:0] direction_bytes;
  } rsp_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [HIST_AW-1:0] addr;
    logic [CNT_W-1:0]   wdata;
  } hist_cmd_t;

endpackage

`default_nettype wire

// ===== src/lhp_if.sv =====
// ----------------------------------------------------------------------------
// Latency histogram channels
// Valid/ready request and response channels carrying one item each.
// ----------------------------------------------------------------------------
`default_nettype none

interface lhp_req_if;
  import lhp_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lhp_rsp_if;
  import lhp_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/latency_histogram_percentile_core.sv =====
// ----------------------------------------------------------------------------
// Latency histogram percentile core
// Records I/O latencies into per-direction log2 buckets, answers percentile
// queries by walking the buckets, and keeps saturating counters.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request item: record (direction, bytes, latency in ns),
//   percentile query (direction, tenths of a percent) or window reset. rsp_o
//   returns exactly one item per request: bucket, percentile in us and the
//   direction's total, window and byte counters after the request.
//   req_i.ready is high only while the sequencer is idle; one item is worked
//   at a time.
//   A record searches for its bucket by comparing the latency against one
//   doubled threshold per cycle, then reads and writes the bucket memory.
//   A query walks the buckets from the first one until the walk stops:
//   each bucket costs one memory read and one accumulate-compare. A query
//   on an empty direction and a window reset go straight from accept to
//   the response.
//   The response sits in an output register; while the receiver stalls, the
//   core still takes and works one more item, then holds it until the
//   output register frees.
//   Reset clears all histogram entries (valid bits), counters and the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "latency_histogram_percentile_core_assert.svh"

module latency_histogram_percentile_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lhp_req_if.sink    req_i,
  lhp_rsp_if.source  rsp_o
);
  import lhp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_BKT  = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_WR   = 8'b0000_1000,
    S_QMUL = 8'b0001_0000,
    S_QRD  = 8'b0010_0000,
    S_QACC = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e             state_q;
  logic [REQ_W-1:0]   kind_q;
  logic               dir_q;
  logic [CNT_W-1:0]   bytes_in_q;
  logic [LAT_W-1:0]   lat_q;
  logic [PCT_W-1:0]   pct_q;
  logic [BKT_W-1:0]   b_q;
  logic [LAT_W:0]     thr_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]   acc_q;
  logic               ans_valid_q;
  logic [CNT_W-1:0]   io_tot_q [2];
  logic [CNT_W-1:0]   win_q    [2];
  logic [BYTES_W-1:0] byt_q    [2];
  logic               rsp_valid_q;
  rsp_t               rsp_q;

  hist_cmd_t          hist_cmd;
  logic [CNT_W-1:0]   entry;
  logic [CNT_W-1:0]   tot_sel;
  logic               lat_ge;
  logic               b_last;
  logic [ACC_W-1:0]   scaled;
  logic [ACC_W-1:0]   acc_sum;
  logic               hit;
  logic [BYTES_W:0]   byte_sum;
  logic [BYTES_W-1:0] byte_next;
  logic               out_free;
  logic               in_acc;
  logic [PCT_W-1:0]   pct_clamped;
  logic [ANS_W-1:0]   answer;

  lhp_hist_mem u_hist_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (hist_cmd),
    .rdata_o (entry)
  );

  assign tot_sel  = io_tot_q[dir_q];
  assign lat_ge   = {1'b0, lat_q} >= thr_q;
  assign b_last   = b_q == BKT_W'(BUCKETS - 1);
  // 1000 * entry as shift and subtract
  assign scaled   = (ACC_W'(entry) << 10) - (ACC_W'(entry) << 4) - (ACC_W'(entry) << 3);
  assign acc_sum  = acc_q + scaled;
  // acc holds 1000 * (sum + 1); sum >= floor(P / 1000) iff it exceeds P
  assign hit      = acc_sum > ACC_W'(prod_q);
  assign byte_sum = {1'b0, byt_q[dir_q]} + (BYTES_W + 1)'(bytes_in_q);
  assign byte_next = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign in_acc   = req_i.valid && req_i.ready;
  assign pct_clamped = (req_i.payload.pct_tenths > PCT_W'(PCT_FULL)) ?
                       PCT_W'(PCT_FULL) : req_i.payload.pct_tenths;

  always_comb begin
    hist_cmd.rd_en = (state_q == S_RD) || (state_q == S_QRD);
    hist_cmd.wr_en = state_q == S_WR;
    hist_cmd.addr  = dir_q ? (HIST_AW'(BUCKETS) + HIST_AW'(b_q)) : HIST_AW'(b_q);
    hist_cmd.wdata = (entry == '1) ? entry : entry + CNT_W'(1);
  end

  always_comb begin
    answer = '0;
    if (ans_valid_q) begin
      if ((BKT_W + 7)'(b_q) < (BKT_W + 7)'(ANS_W)) begin
        answer = ANS_W'(1) << b_q;
      end else begin
        answer = '1;
      end
    end
  end

  assign req_i.ready   = state_q == S_IDLE;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // item payload and walk datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_q     <= req_i.payload.req_type;
          dir_q      <= req_i.payload.is_read;
          bytes_in_q <= req_i.payload.byte_count;
          lat_q      <= req_i.payload.latency_ns;
          pct_q      <= pct_clamped;
          b_q        <= '0;
          thr_q      <= (LAT_W + 1)'(2 * NS_PER_US);
          acc_q      <= ACC_W'(PCT_FULL);
        end
      end
      S_BKT: begin
        if (!b_last && lat_ge) begin
          b_q   <= b_q + BKT_W'(1);
          thr_q <= thr_q << 1;
        end
      end
      S_QMUL: begin
        prod_q <= PROD_W'(tot_sel) * PROD_W'(pct_q);
      end
      S_QACC: begin
        acc_q <= acc_sum;
        if (!hit && !b_last) begin
          b_q <= b_q + BKT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          rsp_q.bucket_index     <= BIDX_W'(b_q);
          rsp_q.percentile_us    <= answer;
          rsp_q.direction_total  <= tot_sel;
          rsp_q.direction_window <= win_q[dir_q];
          rsp_q.direction_bytes  <= byt_q[dir_q];
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ans_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      io_tot_q[0] <= '0;
      io_tot_q[1] <= '0;
      win_q[0]    <= '0;
      win_q[1]    <= '0;
      byt_q[0]    <= '0;
      byt_q[1]    <= '0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.valid && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ans_valid_q <= 1'b0;
            case (req_i.payload.req_type)
              REQ_RECORD: begin
                state_q <= S_BKT;
              end
              REQ_QUERY: begin
                state_q <= (io_tot_q[req_i.payload.is_read] != '0) ? S_QMUL : S_DONE;
              end
              REQ_WINDOW_RESET: begin
                win_q[0] <= '0;
                win_q[1] <= '0;
                state_q  <= S_DONE;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_BKT: begin
          if (b_last || !lat_ge) begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_WR;
        end
        S_WR: begin
          if (tot_sel != '1) begin
            io_tot_q[dir_q] <= tot_sel + CNT_W'(1);
          end
          if (win_q[dir_q] != '1) begin
            win_q[dir_q] <= win_q[dir_q] + CNT_W'(1);
          end
          byt_q[dir_q] <= byte_next;
          state_q      <= S_DONE;
        end
        S_QMUL: begin
          ans_valid_q <= 1'b1;
          state_q     <= S_QRD;
        end
        S_QRD: begin
          state_q <= S_QACC;
        end
        S_QACC: begin
          state_q <= (hit || b_last) ? S_DONE : S_QRD;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `LHP_ASSERT_NXT(a_accept_leaves_idle, clk_i, rst_ni, in_acc, state_q != S_IDLE, "item accepted but sequencer stayed idle")
  `LHP_ASSERT_IMP(a_walk_nonempty, clk_i, rst_ni, state_q == S_QACC, tot_sel != '0 && kind_q == REQ_QUERY, "bucket walk on an empty direction")
  `LHP_ASSERT_NXT(a_done_emits, clk_i, rst_ni, state_q == S_DONE && out_free, rsp_o.valid && state_q == S_IDLE, "finished item not presented")

endmodule

`default_nettype wire

// ===== src/lhp_hist_mem.sv =====
// ----------------------------------------------------------------------------
// Histogram bucket store
// One-port bucket memory with registered read and per-entry valid bits;
// an entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_hist_mem (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lhp_pkg::hist_cmd_t        cmd_i,
  output logic [lhp_pkg::CNT_W-1:0]      rdata_o
);
  import lhp_pkg::*;

  logic [CNT_W-1:0]      mem_q [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] valid_q;
  logic [CNT_W-1:0]      rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.addr] <= cmd_i.wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rvalid_q <= valid_q[cmd_i.addr];
      end
      if (cmd_i.wr_en) begin
        valid_q[cmd_i.addr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire
